>>> hdl/ece_pkg.sv
// Shared types, constants and tables for the easing curve evaluator.
// No dependencies; imported by every module of the block.
package ece_pkg;

    localparam int FRAC_W   = 16;
    localparam int TIME_W   = 16;
    localparam int VALUE_W  = 16;
    localparam int CHANGE_W = 17;
    localparam int CORDIC_N = 31;

    localparam logic [16:0] ONE_Q       = 17'h1_0000;
    localparam logic [31:0] Q30_ONE     = 32'h4000_0000;
    localparam logic [33:0] CORDIC_X0   = 34'h0_26DD_3B6A;
    localparam logic [30:0] HALF_PI_Q30 = 31'h6487_ED51;

    typedef logic [31:0] t_atan_tab [0:30];
    localparam t_atan_tab ATAN_Q30 = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
        32'h00000001
    };

    typedef enum logic [2:0] {G_LIN, G_POLY, G_SINE, G_EXP, G_CIRC} t_group;
    typedef enum logic [1:0] {V_IN, V_OUT, V_INOUT} t_variant;

    typedef struct packed {
        t_group     grp;
        t_variant   vnt;
        logic [2:0] pn;
    } t_kdec;

    typedef struct packed {
        t_kdec              kd;
        logic               done;
        logic signed [15:0] start;
        logic signed [16:0] change;
        logic [15:0]        u;
        logic               half;
        logic               uzero;
    } t_side;

    function automatic logic [63:0] isqrt64(input logic [63:0] n);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        v   = n;
        res = '0;
        b   = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // 2^(2^-k) in Q2.30, k = 1..16
    typedef logic [31:0] t_exp_tab [1:16];
    function automatic t_exp_tab exp_table();
        t_exp_tab    tab;
        logic [63:0] t;
        t = isqrt64(64'd1 << 61);
        for (int k = 1; k <= 16; k++) begin
            tab[k] = t[31:0];
            t      = isqrt64(t << 30);
        end
        return tab;
    endfunction

    localparam t_exp_tab EXP_T = exp_table();

    function automatic t_kdec kind_decode(input logic [4:0] kind);
        t_kdec d;
        d.grp = G_LIN;
        d.vnt = V_INOUT;
        d.pn  = 3'd5;
        case (kind) inside
            [5'd1:5'd12]:  d.grp = G_POLY;
            [5'd13:5'd15]: d.grp = G_SINE;
            [5'd16:5'd18]: d.grp = G_EXP;
            [5'd19:5'd21]: d.grp = G_CIRC;
            default:       d.grp = G_LIN;
        endcase
        case (kind) inside
            5'd1, 5'd4, 5'd7, 5'd10, 5'd13, 5'd16, 5'd19: d.vnt = V_IN;
            5'd2, 5'd5, 5'd8, 5'd11, 5'd14, 5'd17, 5'd20: d.vnt = V_OUT;
            default:                                      d.vnt = V_INOUT;
        endcase
        case (kind) inside
            [5'd1:5'd3]: d.pn = 3'd2;
            [5'd4:5'd6]: d.pn = 3'd3;
            [5'd7:5'd9]: d.pn = 3'd4;
            default:     d.pn = 3'd5;
        endcase
        return d;
    endfunction

endpackage

>>> hdl/ece_div.sv
// Pipelined restoring divider: u = floor(t * 2^16 / d), one quotient bit per stage.
// Depends on ece_pkg.
module ece_div import ece_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [TIME_W-1:0] i_t,
    input  logic [TIME_W-1:0] i_d,
    output logic [FRAC_W-1:0] o_u
);

    logic [15:0] r_rem [0:15];
    logic [15:0] r_q   [0:15];
    logic [15:0] r_d   [0:14];

    genvar k;
    for (k = 0; k < 16; k++) begin : g_st
        logic [15:0] w_rin;
        logic [15:0] w_din;
        logic [15:0] w_qin;
        logic [16:0] w_sh;
        logic [16:0] w_dif;
        logic        w_ge;
        if (k == 0) begin : g_first
            assign w_rin = i_t;
            assign w_din = i_d;
            assign w_qin = '0;
        end else begin : g_next
            assign w_rin = r_rem[k-1];
            assign w_din = r_d[k-1];
            assign w_qin = r_q[k-1];
        end
        assign w_sh  = {w_rin, 1'b0};
        assign w_ge  = w_sh >= {1'b0, w_din};
        assign w_dif = w_sh - {1'b0, w_din};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? w_dif[15:0] : w_sh[15:0];
                r_q[k]   <= {w_qin[14:0], w_ge};
            end
        end
        if (k < 15) begin : g_dcarry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_d[k] <= w_din;
                end
            end
        end
    end

    assign o_u = r_q[15];

endmodule

>>> hdl/ece_poly.sv
// Power unit: x^n for n = 2..5 as a chain of four floored Q1.16 products.
// Depends on ece_pkg.
module ece_poly import ece_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [16:0] i_x,
    input  logic [2:0]  i_n,
    output logic [16:0] o_p
);

    logic [16:0] r_p [0:3];
    logic [16:0] r_x [0:2];
    logic [2:0]  r_n [0:2];

    genvar j;
    for (j = 0; j < 4; j++) begin : g_st
        logic [16:0] w_pin;
        logic [16:0] w_xin;
        logic [2:0]  w_nin;
        logic [33:0] w_prod;
        if (j == 0) begin : g_first
            assign w_pin = i_x;
            assign w_xin = i_x;
            assign w_nin = i_n;
        end else begin : g_next
            assign w_pin = r_p[j-1];
            assign w_xin = r_x[j-1];
            assign w_nin = r_n[j-1];
        end
        assign w_prod = w_pin * w_xin;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_p[j] <= (3'(j + 1) < w_nin) ? w_prod[32:16] : w_pin;
            end
        end
        if (j < 3) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x[j] <= w_xin;
                    r_n[j] <= w_nin;
                end
            end
        end
    end

    assign o_p = r_p[3];

endmodule

>>> hdl/ece_cordic.sv
// Rotation-mode CORDIC, one iteration per stage, giving sin, cos and sin^2 of u*pi/2.
// Depends on ece_pkg (gain, angle scale and arctangent table).
module ece_cordic import ece_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [FRAC_W-1:0] i_u,
    output logic [16:0]       o_sin,
    output logic [16:0]       o_cos,
    output logic [17:0]       o_sq
);

    logic signed [33:0] r_x [0:CORDIC_N];
    logic signed [33:0] r_y [0:CORDIC_N];
    logic signed [33:0] r_z [0:CORDIC_N-1];
    logic [46:0]        w_z0;
    logic [16:0]        w_sc;
    logic [16:0]        w_cc;
    logic [33:0]        w_sq;

    function automatic logic [16:0] q30_clamp(input logic signed [33:0] v);
        logic [16:0] r;
        if (v[33]) begin
            r = '0;
        end else if (v > $signed({2'b00, Q30_ONE})) begin
            r = ONE_Q;
        end else begin
            r = v[30:14];
        end
        return r;
    endfunction

    assign w_z0 = {31'b0, i_u} * {16'b0, HALF_PI_Q30};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= $signed(CORDIC_X0);
            r_y[0] <= '0;
            r_z[0] <= $signed({3'b000, w_z0[46:16]});
            for (int i = 0; i < CORDIC_N; i++) begin
                if (!r_z[i][33]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    if (i < CORDIC_N - 1) begin
                        r_z[i+1] <= r_z[i] - $signed({2'b00, ATAN_Q30[i]});
                    end
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    if (i < CORDIC_N - 1) begin
                        r_z[i+1] <= r_z[i] + $signed({2'b00, ATAN_Q30[i]});
                    end
                end
            end
        end
    end

    assign w_sc = q30_clamp(r_y[CORDIC_N]);
    assign w_cc = q30_clamp(r_x[CORDIC_N]);
    assign w_sq = w_sc * w_sc;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_sin <= w_sc;
            o_cos <= w_cc;
            o_sq  <= w_sq[32:15];
        end
    end

endmodule

>>> hdl/ece_exp2.sv
// 2^(-m/2^16) in Q1.16: product of 2^(2^-k) table entries, one per stage, then a shift.
// Depends on ece_pkg (EXP_T table).
module ece_exp2 import ece_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [19:0] i_m,
    output logic [16:0] o_e
);

    logic [31:0] r_p  [0:15];
    logic [15:0] r_q  [0:14];
    logic [3:0]  r_n  [0:15];
    logic        r_rz [0:15];
    logic [15:0] w_q0;

    assign w_q0 = 16'd0 - i_m[15:0];

    genvar k;
    for (k = 0; k < 16; k++) begin : g_st
        logic [31:0] w_pin;
        logic [15:0] w_qin;
        logic [3:0]  w_nin;
        logic        w_rzin;
        logic [63:0] w_prod;
        if (k == 0) begin : g_first
            assign w_pin  = Q30_ONE;
            assign w_qin  = w_q0;
            assign w_nin  = i_m[19:16];
            assign w_rzin = (i_m[15:0] == '0);
        end else begin : g_next
            assign w_pin  = r_p[k-1];
            assign w_qin  = r_q[k-1];
            assign w_nin  = r_n[k-1];
            assign w_rzin = r_rz[k-1];
        end
        assign w_prod = {32'b0, w_pin} * {32'b0, EXP_T[k+1]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_p[k]  <= w_qin[15-k] ? w_prod[61:30] : w_pin;
                r_n[k]  <= w_nin;
                r_rz[k] <= w_rzin;
            end
        end
        if (k < 15) begin : g_qcarry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_q[k] <= w_qin;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_e <= r_rz[15] ? (ONE_Q >> r_n[15])
                            : 17'(r_p[15] >> ({1'b0, r_n[15]} + 5'd15));
        end
    end

endmodule

>>> hdl/ece_circ.sv
// Circular root sqrt(1 - x^2) in Q1.16: squaring stage, then one root digit per stage.
// Depends on ece_pkg.
module ece_circ import ece_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [16:0] i_x,
    output logic [16:0] o_root
);

    logic [33:0] w_sq;
    logic [33:0] r_rad [0:16];
    logic [19:0] r_rem [0:16];
    logic [16:0] r_rt  [0:16];

    assign w_sq = i_x * i_x;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad[0] <= 34'h1_0000_0000 - w_sq;
        end
    end

    genvar j;
    for (j = 0; j < 17; j++) begin : g_st
        logic [19:0] w_rin;
        logic [16:0] w_tin;
        logic [21:0] w_cur;
        logic [21:0] w_trial;
        logic [21:0] w_dif;
        logic        w_ge;
        if (j == 0) begin : g_first
            assign w_rin = '0;
            assign w_tin = '0;
        end else begin : g_next
            assign w_rin = r_rem[j-1];
            assign w_tin = r_rt[j-1];
        end
        assign w_cur   = {w_rin, r_rad[j][33-2*j -: 2]};
        assign w_trial = {3'b000, w_tin, 2'b01};
        assign w_ge    = w_cur >= w_trial;
        assign w_dif   = w_cur - w_trial;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= w_ge ? w_dif[19:0] : w_cur[19:0];
                r_rt[j]  <= {w_tin[15:0], w_ge};
            end
        end
        if (j < 16) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rad[j+1] <= r_rad[j];
                end
            end
        end
    end

    assign o_root = r_rt[16];

endmodule

>>> hdl/easing_curve_evaluator.sv
// Easing curve evaluator top level: divider, curve units, selection and scaling.
// Throughput: one request per cycle; the whole pipeline holds while its last stage
// is full and the output register is not taken. Synchronous active-low reset clears
// the valid bits only.
// Depends on ece_pkg, ece_div, ece_poly, ece_cordic, ece_exp2, ece_circ.
module easing_curve_evaluator import ece_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [71:0] i_s_axis_tdata,  // elapsed_time[15:0], duration[31:16],
                                         // start_value[47:32], change[64:48]
    input  logic [4:0]  i_s_axis_tuser,  // kind
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,  // eased_value
    output logic        o_m_axis_tlast   // finished
);

    localparam int PREP_IX  = 16;
    localparam int UNIT_LAT = 33;
    localparam int SEL_IX   = PREP_IX + UNIT_LAT + 1;
    localparam int DEPTH    = SEL_IX + 2;
    localparam int POLY_DLY = UNIT_LAT - 4;
    localparam int EXP_DLY  = UNIT_LAT - 17;
    localparam int CIRC_DLY = UNIT_LAT - 18;

    logic              w_adv;
    logic [DEPTH-1:0]  r_vld;
    t_side             r_side [0:DEPTH-1];
    t_side             w_in_side;
    t_side             w_prep_side;
    t_side             w_sel_side;
    t_side             w_out_side;
    logic [15:0]       w_u;
    logic [16:0]       w_omu;
    logic [16:0]       w_pb;
    logic [16:0]       w_earg;
    logic [16:0]       r_pb;
    logic [19:0]       r_em;
    logic [16:0]       w_poly;
    logic [16:0]       w_sin;
    logic [16:0]       w_cos;
    logic [17:0]       w_sq;
    logic [16:0]       w_exp;
    logic [16:0]       w_root;
    logic [16:0]       r_pd [0:POLY_DLY-1];
    logic [16:0]       r_ed [0:EXP_DLY-1];
    logic [16:0]       r_cd [0:CIRC_DLY-1];
    logic [17:0]       w_f;
    logic [17:0]       r_f;
    logic [16:0]       w_mag;
    logic [34:0]       w_prod;
    logic [17:0]       r_part;
    logic signed [19:0] w_start;
    logic signed [19:0] w_part;
    logic signed [19:0] w_end;
    logic signed [19:0] w_sum;
    logic signed [19:0] w_res;
    logic [15:0]       w_sat;
    logic              r_out_vld;
    logic [15:0]       r_out_data;
    logic              r_out_last;

    assign w_adv           = !r_vld[DEPTH-1] || !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;

    always_comb begin
        w_in_side        = '0;
        w_in_side.kd     = kind_decode(i_s_axis_tuser);
        w_in_side.done   = i_s_axis_tdata[15:0] >= i_s_axis_tdata[31:16];
        w_in_side.start  = i_s_axis_tdata[47:32];
        w_in_side.change = i_s_axis_tdata[64:48];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[DEPTH-2:0], i_s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_side[0] <= w_in_side;
            for (int k = 1; k < DEPTH; k++) begin
                r_side[k] <= (k == PREP_IX) ? w_prep_side : r_side[k-1];
            end
        end
    end

    ece_div u_div (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_t   (i_s_axis_tdata[15:0]),
        .i_d   (i_s_axis_tdata[31:16]),
        .o_u   (w_u)
    );

    // operand preparation
    assign w_omu = ONE_Q - {1'b0, w_u};

    always_comb begin
        w_prep_side       = r_side[PREP_IX-1];
        w_prep_side.u     = w_u;
        w_prep_side.half  = ~w_u[15];
        w_prep_side.uzero = (w_u == '0);
        case (r_side[PREP_IX-1].kd.vnt)
            V_IN: begin
                w_pb   = {1'b0, w_u};
                w_earg = w_omu;
            end
            V_OUT: begin
                w_pb   = w_omu;
                w_earg = {1'b0, w_u};
            end
            V_INOUT: begin
                w_pb   = ~w_u[15] ? {w_u, 1'b0} : {w_omu[15:0], 1'b0};
                w_earg = ~w_u[15] ? (ONE_Q - {w_u, 1'b0}) : ({w_u, 1'b0} - ONE_Q);
            end
            default: begin
                w_pb   = {1'b0, w_u};
                w_earg = w_omu;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pb <= w_pb;
            r_em <= {w_earg, 3'b000} + {2'b00, w_earg, 1'b0};
        end
    end

    ece_poly u_poly (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_x   (r_pb),
        .i_n   (r_side[PREP_IX].kd.pn),
        .o_p   (w_poly)
    );

    ece_cordic u_cordic (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_u   (r_side[PREP_IX].u),
        .o_sin (w_sin),
        .o_cos (w_cos),
        .o_sq  (w_sq)
    );

    ece_exp2 u_exp2 (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_m   (r_em),
        .o_e   (w_exp)
    );

    ece_circ u_circ (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_x    (r_pb),
        .o_root (w_root)
    );

    // align the shorter units with the CORDIC
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pd[0] <= w_poly;
            r_ed[0] <= w_exp;
            r_cd[0] <= w_root;
            for (int k = 1; k < POLY_DLY; k++) begin
                r_pd[k] <= r_pd[k-1];
            end
            for (int k = 1; k < EXP_DLY; k++) begin
                r_ed[k] <= r_ed[k-1];
            end
            for (int k = 1; k < CIRC_DLY; k++) begin
                r_cd[k] <= r_cd[k-1];
            end
        end
    end

    // curve shape in units of 2^-17
    assign w_sel_side = r_side[SEL_IX-1];

    always_comb begin
        case (w_sel_side.kd.grp)
            G_POLY: begin
                case (w_sel_side.kd.vnt)
                    V_IN:    w_f = {r_pd[POLY_DLY-1], 1'b0};
                    V_OUT:   w_f = {ONE_Q - r_pd[POLY_DLY-1], 1'b0};
                    default: w_f = w_sel_side.half ? {1'b0, r_pd[POLY_DLY-1]}
                                   : {ONE_Q, 1'b0} - {1'b0, r_pd[POLY_DLY-1]};
                endcase
            end
            G_SINE: begin
                case (w_sel_side.kd.vnt)
                    V_IN:    w_f = {ONE_Q - w_cos, 1'b0};
                    V_OUT:   w_f = {w_sin, 1'b0};
                    default: w_f = w_sq;
                endcase
            end
            G_EXP: begin
                case (w_sel_side.kd.vnt)
                    V_IN:    w_f = w_sel_side.uzero ? '0 : {r_ed[EXP_DLY-1], 1'b0};
                    V_OUT:   w_f = {ONE_Q - r_ed[EXP_DLY-1], 1'b0};
                    default: w_f = w_sel_side.uzero ? '0
                                   : w_sel_side.half ? {1'b0, r_ed[EXP_DLY-1]}
                                   : {ONE_Q, 1'b0} - {1'b0, r_ed[EXP_DLY-1]};
                endcase
            end
            G_CIRC: begin
                case (w_sel_side.kd.vnt)
                    V_IN:    w_f = {ONE_Q - r_cd[CIRC_DLY-1], 1'b0};
                    V_OUT:   w_f = {r_cd[CIRC_DLY-1], 1'b0};
                    default: w_f = w_sel_side.half ? {1'b0, ONE_Q - r_cd[CIRC_DLY-1]}
                                   : {1'b0, ONE_Q} + {1'b0, r_cd[CIRC_DLY-1]};
                endcase
            end
            default: w_f = {1'b0, w_sel_side.u, 1'b0};
        endcase
    end

    assign w_mag  = r_side[SEL_IX].change[16] ? (~r_side[SEL_IX].change + 17'd1)
                                              : r_side[SEL_IX].change;
    assign w_prod = {18'b0, w_mag} * {17'b0, r_f};

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_f    <= w_f;
            r_part <= w_prod[34:17];
        end
    end

    // sign, sum and saturation
    assign w_out_side = r_side[DEPTH-1];
    assign w_start    = {{4{w_out_side.start[15]}}, w_out_side.start};
    assign w_part     = $signed({2'b00, r_part});
    assign w_end      = w_start + {{3{w_out_side.change[16]}}, w_out_side.change};
    assign w_sum      = w_out_side.change[16] ? (w_start - w_part) : (w_start + w_part);
    assign w_res      = w_out_side.done ? w_end : w_sum;

    always_comb begin
        if (w_res > 20'sd32767) begin
            w_sat = 16'h7FFF;
        end else if (w_res < -20'sd32768) begin
            w_sat = 16'h8000;
        end else begin
            w_sat = w_res[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv && r_vld[DEPTH-1]) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_vld[DEPTH-1]) begin
            r_out_data <= w_sat;
            r_out_last <= w_out_side.done;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

endmodule
